// File: rtl/autokey_shift_cipher_27_core_macros.svh
// assertion macros for the autokey cipher core
// expects clk and arst_n in the scope where the macros are used
`ifndef AUTOKEY_SHIFT_CIPHER_27_CORE_MACROS_SVH
`define AUTOKEY_SHIFT_CIPHER_27_CORE_MACROS_SVH

// condition in the same cycle
`define AKC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition in the following cycle
`define AKC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/akc_pkg.sv
// shared types, constants and symbol coding functions for the autokey cipher core
// no dependencies
package akc_pkg;

	localparam int MaxLen = 64;
	localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
	localparam int CountW = $clog2(MaxLen + 1);
	localparam int Alpha = 27;
	localparam logic [4:0] SymSpace = 5'd26;
	localparam logic [7:0] CharA = 8'h41;
	localparam logic [7:0] CharLowA = 8'h61;
	localparam logic [7:0] CharLowZ = 8'h7a;
	localparam logic [7:0] CharZ = 8'h5a;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab = 8'h09;
	localparam logic [7:0] CharCr = 8'h0d;
	localparam logic [7:0] CaseDelta = 8'h20;

	// configuration register indexes
	localparam logic [1:0] RegKey = 2'd0;
	localparam logic [1:0] RegDecrypt = 2'd1;
	localparam logic [1:0] RegReverse = 2'd2;

	typedef struct packed {
		logic is_sym;
		logic [4:0] idx;
	} sym_t;

	typedef struct packed {
		logic [7:0] data;
		sym_t sym;
		logic last;
		logic first;
		logic dec;
		logic rev;
		logic [4:0] key;
	} qent_t;

	typedef struct packed {
		logic [7:0] code;
		logic [4:0] next_shift;
	} code_res_t;

	typedef struct packed {
		logic draining;
		logic ovf;
		logic [CountW-1:0] count;
	} back_status_t;

	function automatic logic [4:0] mod27_add(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 6'(Alpha)) ? 5'(s - 6'(Alpha)) : s[4:0];
	endfunction

	function automatic sym_t classify(input logic [7:0] b);
		sym_t r;
		logic [7:0] u;
		u = (b >= CharLowA && b <= CharLowZ) ? b - CaseDelta : b;
		r.is_sym = 1'b0;
		r.idx = SymSpace;
		if (u >= CharA && u <= CharZ) begin
			r.is_sym = 1'b1;
			r.idx = 5'(u - CharA);
		end else if (u == CharSpace || (u >= CharTab && u <= CharCr)) begin
			r.is_sym = 1'b1;
		end
		return r;
	endfunction

	// codes one byte and gives the shift for the next symbol
	function automatic code_res_t code_sym(input sym_t s, input logic [7:0] raw,
		input logic [4:0] shift, input logic dec, input logic [4:0] key);
		code_res_t r;
		logic [4:0] o;
		logic [4:0] neg;
		logic [4:0] part;
		neg = 5'(6'(Alpha) - {1'b0, shift});
		o = dec ? mod27_add(s.idx, neg) : mod27_add(s.idx, shift);
		part = mod27_add(shift, dec ? o : s.idx);
		if (s.is_sym) begin
			r.code = (o == SymSpace) ? CharSpace : CharA + {3'b0, o};
			r.next_shift = mod27_add(part, key);
		end else begin
			r.code = raw;
			r.next_shift = shift;
		end
		return r;
	endfunction

endpackage

// File: rtl/autokey_shift_cipher_27_core.sv
// autokey shift cipher core, 27-symbol alphabet (A-Z and space)
// forward mode: result held in a queue entry, then in the output register, one word
// per cycle while the output is not stalled
// reverse mode: bytes buffered at one per cycle while no message is draining,
// then each word drains through the RD and OUT states (registered store read)
// reset (arst_n low, asynchronous): key 1, encrypt, forward, no message open
`include "autokey_shift_cipher_27_core_macros.svh"
module autokey_shift_cipher_27_core import akc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_wdata,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       overflow,
	output logic       out_valid,
	input  logic       out_ready
);

	logic         push_valid;
	logic         push_ready;
	qent_t        push_data;
	logic         pop_valid;
	logic         pop_ready;
	qent_t        pop_data;
	back_status_t bstat;

	akc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	akc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	akc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_byte (out_byte),
		.out_last (out_last),
		.out_ovf  (overflow),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (bstat)
	);

	`AKC_ASSERT_IMP(a_no_pop_in_drain, bstat.draining, !pop_ready, "queue popped during drain")
	`AKC_ASSERT_IMP(a_count_bound, 1'b1, bstat.count <= CountW'(MaxLen), "store count too large")
	`AKC_ASSERT_IMP(a_ovf_full, bstat.draining && bstat.ovf, bstat.count == CountW'(MaxLen),
		"overflow with store not full")
	`AKC_ASSERT_NEXT(a_fwd_result, pop_valid && pop_ready && !pop_data.rev, out_valid,
		"forward word lost")

endmodule

// File: rtl/akc_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module akc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/akc_front.sv
// front end: configuration registers, per-message latching and byte classification
// depends on akc_pkg
module akc_front import akc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_wdata,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        push_valid,
	input  logic        push_ready,
	output qent_t       push_data
);

	logic [4:0] key_q;
	logic       dec_q;
	logic       rev_q;
	logic       busy_q;
	logic [4:0] key_lat_q;
	logic       dec_lat_q;
	logic       rev_lat_q;
	logic [4:0] key_mod;
	logic       accept;

	assign key_mod = (key_q >= 5'(Alpha)) ? 5'(key_q - 5'(Alpha)) : key_q;
	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign accept = in_valid && push_ready;

	always_comb begin
		push_data.data = in_byte;
		push_data.sym = classify(in_byte);
		push_data.last = in_last;
		push_data.first = !busy_q;
		push_data.dec = busy_q ? dec_lat_q : dec_q;
		push_data.rev = busy_q ? rev_lat_q : rev_q;
		push_data.key = busy_q ? key_lat_q : key_mod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= 5'd1;
			dec_q <= 1'b0;
			rev_q <= 1'b0;
			busy_q <= 1'b0;
			key_lat_q <= 5'd1;
			dec_lat_q <= 1'b0;
			rev_lat_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					RegKey: key_q <= cfg_wdata;
					RegDecrypt: dec_q <= cfg_wdata[0];
					RegReverse: rev_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (accept) begin
				busy_q <= !in_last;
				if (!busy_q) begin
					key_lat_q <= key_mod;
					dec_lat_q <= dec_q;
					rev_lat_q <= rev_q;
				end
			end
		end
	end

endmodule

// File: rtl/akc_queue.sv
// two-entry word queue between front and back ends
// depends on akc_pkg
module akc_queue import akc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  qent_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output qent_t pop_data
);

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_data = ent_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/akc_back.sv
// back end: running shift, message store, reverse drain and output register
// depends on akc_pkg and akc_ram
module akc_back import akc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  qent_t        pop_data,
	output logic [7:0]   out_byte,
	output logic         out_last,
	output logic         out_ovf,
	output logic         out_valid,
	input  logic         out_ready,
	output back_status_t status
);

	typedef enum logic [1:0] {
		RUN,
		RD,
		OUT
	} state_t;

	state_t            state_q;
	logic [4:0]        shift_q;
	logic [CountW-1:0] count_q;
	logic              ovf_q;
	logic              dec_q;
	logic [4:0]        key_q;
	logic [AddrW-1:0]  rd_ptr_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic [4:0]        eff_shift;
	logic [CountW-1:0] eff_cnt;
	logic              eff_ovf;
	logic              has_room;
	logic [CountW-1:0] cnt_next;
	code_res_t         enc_res;
	code_res_t         drn_res;
	logic              out_free;
	logic              fire;
	logic              out_load;
	logic              ram_we;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;
	logic [7:0]        drn_byte;

	always_comb begin
		eff_shift = pop_data.first ? pop_data.key : shift_q;
		eff_cnt = pop_data.first ? '0 : count_q;
		eff_ovf = pop_data.first ? 1'b0 : ovf_q;
		has_room = (eff_cnt < CountW'(MaxLen));
		cnt_next = has_room ? eff_cnt + 1'b1 : eff_cnt;
		enc_res = code_sym(pop_data.sym, pop_data.data, eff_shift, pop_data.dec, pop_data.key);
		out_free = !out_valid_q || out_ready;
		pop_ready = (state_q == RUN) && (pop_data.rev || out_free);
		fire = pop_valid && pop_ready;
		// a new word enters the output register
		out_load = (fire && !pop_data.rev) || ((state_q == OUT) && out_free);
		ram_we = fire && pop_data.rev && has_room;
		// decrypt keeps raw bytes and codes them on the way out
		ram_wdata = pop_data.dec ? pop_data.data : enc_res.code;
		ram_re = (state_q == RD);
		drn_res = code_sym(classify(ram_rdata), ram_rdata, shift_q, 1'b1, key_q);
		drn_byte = dec_q ? drn_res.code : ram_rdata;
	end

	akc_ram #(
		.WIDTH(8),
		.DEPTH(MaxLen)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(eff_cnt[AddrW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RUN;
			shift_q <= 5'd0;
			count_q <= '0;
			ovf_q <= 1'b0;
			dec_q <= 1'b0;
			key_q <= 5'd0;
			rd_ptr_q <= '0;
			out_valid_q <= 1'b0;
			out_byte_q <= 8'd0;
			out_last_q <= 1'b0;
			out_ovf_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				RUN: begin
					if (fire) begin
						dec_q <= pop_data.dec;
						key_q <= pop_data.key;
						if (!pop_data.rev) begin
							shift_q <= enc_res.next_shift;
							out_byte_q <= enc_res.code;
							out_last_q <= pop_data.last;
							out_ovf_q <= 1'b0;
						end else begin
							count_q <= cnt_next;
							ovf_q <= eff_ovf || !has_room;
							// dropped bytes are never coded
							shift_q <= (has_room && !pop_data.dec) ?
								enc_res.next_shift : eff_shift;
							if (pop_data.last) begin
								rd_ptr_q <= AddrW'(cnt_next - 1'b1);
								state_q <= RD;
							end
						end
					end
				end
				RD: begin
					state_q <= OUT;
				end
				OUT: begin
					if (out_free) begin
						out_byte_q <= drn_byte;
						out_last_q <= (rd_ptr_q == '0);
						out_ovf_q <= ovf_q;
						if (dec_q) begin
							shift_q <= drn_res.next_shift;
						end
						if (rd_ptr_q == '0) begin
							state_q <= RUN;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
							state_q <= RD;
						end
					end
				end
				default: state_q <= RUN;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign out_ovf = out_ovf_q;
	assign status.draining = (state_q != RUN);
	assign status.ovf = ovf_q;
	assign status.count = count_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for autokey_shift_cipher_27_core, forward and reversed messages
// depends on akc_pkg and the core rtl; holds its own cipher predictor
module tb_top;
	import akc_pkg::*;

	localparam int SymCount = 27;
	localparam int SpaceSym = 26;
	localparam logic [1:0] RegUnused = 2'd3;
	localparam int SettleCycles = 8;
	localparam int RandomStop = 330;
	localparam int CycleLimit = 200000;

	typedef struct packed {
		logic [7:0] code;
		logic last;
		logic ovf;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = RegKey;
	logic [4:0] cfg_wdata = '0;
	logic [7:0] in_byte = '0;
	logic in_last = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] out_byte;
	logic out_last;
	logic overflow;
	logic out_valid;
	logic out_ready = 1'b0;

	autokey_shift_cipher_27_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_byte(in_byte),
		.in_last(in_last),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_byte(out_byte),
		.out_last(out_last),
		.overflow(overflow),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies as written, and per-message latched settings
	logic [4:0] key_reg = 5'd1;
	logic dec_reg = 1'b0;
	logic rev_reg = 1'b0;
	int msg_key = 1;
	logic msg_dec = 1'b0;
	logic msg_rev = 1'b0;
	logic msg_open = 1'b0;
	int run_shift = 1;
	logic [7:0] held_bytes [MaxLen];
	int held_count = 0;
	logic held_ovf = 1'b0;

	word_t expected_words[$];
	int err_count = 0;
	int words_sent = 0;
	int cycles = 0;
	int in_gap_pct = 25;
	int out_stall_pct = 25;
	int stall_left = 0;
	logic calm = 1'b0;

	function automatic logic [7:0] cipher_symbol(input logic [7:0] b);
		logic [7:0] u;
		int sym;
		int outsym;
		u = (b >= CharLowA && b <= CharLowZ) ? b - CaseDelta : b;
		if (u >= CharA && u <= CharZ)
			sym = u - CharA;
		else if (u == CharSpace || (u >= CharTab && u <= CharCr))
			sym = SpaceSym;
		else
			return u;
		if (msg_dec) begin
			outsym = (sym + SymCount - run_shift) % SymCount;
			run_shift = (run_shift + outsym + msg_key) % SymCount;
		end else begin
			outsym = (sym + run_shift) % SymCount;
			run_shift = (run_shift + sym + msg_key) % SymCount;
		end
		return (outsym == SpaceSym) ? CharSpace : CharA + 8'(outsym);
	endfunction

	function automatic void push_word(input logic [7:0] c, input logic l, input logic o);
		word_t w;
		w = '{code: c, last: l, ovf: o};
		expected_words.push_back(w);
	endfunction

	// updates the predicted state for one accepted word
	function automatic void absorb_word(input logic [7:0] b, input logic l);
		logic [7:0] coded [MaxLen];
		if (!msg_open) begin
			msg_key = key_reg % SymCount;
			msg_dec = dec_reg;
			msg_rev = rev_reg;
			run_shift = msg_key;
			held_count = 0;
			held_ovf = 1'b0;
			msg_open = 1'b1;
		end
		if (!msg_rev) begin
			push_word(cipher_symbol(b), l, 1'b0);
			if (l)
				msg_open = 1'b0;
			return;
		end
		if (held_count < MaxLen) begin
			held_bytes[held_count] = b;
			held_count++;
		end else begin
			held_ovf = 1'b1;
		end
		if (!l)
			return;
		// encrypt codes in arrival order, decrypt codes the reversed message
		for (int k = 0; k < held_count; k++)
			coded[k] = cipher_symbol(msg_dec ? held_bytes[held_count - 1 - k] : held_bytes[k]);
		for (int k = 0; k < held_count; k++)
			push_word(msg_dec ? coded[k] : coded[held_count - 1 - k], k == held_count - 1,
				held_ovf);
		msg_open = 1'b0;
		held_count = 0;
		held_ovf = 1'b0;
	endfunction

	task automatic log_error(input string what);
		err_count++;
		if (err_count <= 10)
			$display("%0t ns: %s", $time, what);
	endtask

	// result side: check accepted words, then pick the next ready level
	always @(posedge clk) begin
		word_t want;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			if (arst_n && out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					log_error($sformatf("unexpected word byte %02h last %0b ovf %0b",
						out_byte, out_last, overflow));
				end else begin
					want = expected_words.pop_front();
					if (out_byte !== want.code || out_last !== want.last
						|| overflow !== want.ovf)
						log_error($sformatf({"word mismatch: got byte %02h last %0b ovf %0b,",
							" expected byte %02h last %0b ovf %0b"}, out_byte, out_last,
							overflow, want.code, want.last, want.ovf));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(99) < out_stall_pct) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// valid is left high after the handshake so back-to-back words are sent with no gap
	task automatic send_word(input logic [7:0] b, input logic l);
		if (!calm && $urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_byte <= b;
		in_last <= l;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		absorb_word(b, l);
		words_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_word(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic send_message(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: b = ($urandom_range(1) ? CharA : CharLowA) + 8'($urandom_range(25));
				5, 6: b = $urandom_range(1) ? CharSpace : 8'($urandom_range(9, 13));
				default: b = 8'($urandom_range(255));
			endcase
			send_word(b, i == len - 1);
		end
	endtask

	// reverse mode can still be busy after its last result, hence the settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic configure(input logic [4:0] k, input logic d, input logic r);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= RegKey;
		cfg_wdata <= k;
		@(posedge clk);
		key_reg = k;
		cfg_index <= RegDecrypt;
		cfg_wdata <= {4'($urandom_range(15)), d};
		@(posedge clk);
		dec_reg = d;
		cfg_index <= RegReverse;
		cfg_wdata <= {4'($urandom_range(15)), r};
		@(posedge clk);
		rev_reg = r;
		// writes to the spare index must not land anywhere
		cfg_index <= RegUnused;
		cfg_wdata <= 5'($urandom_range(31));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_reset_forward();
		// letter and whitespace range edges, plus bytes just outside them
		send_bytes('{8'h41, 8'h7a, 8'h20, 8'h09, 8'h0d, 8'h08, 8'h0e, 8'h00, 8'hff,
			8'h40, 8'h5b, 8'h60, 8'h7b});
	endtask

	task automatic test_key_wrap();
		configure(5'd27, 1'b0, 1'b0);
		send_bytes('{8'h5a, 8'h61});
		configure(5'd31, 1'b1, 1'b0);
		send_bytes('{8'h51, 8'h0b});
	endtask

	task automatic test_reverse_short();
		configure(5'd26, 1'b0, 1'b1);
		send_bytes('{8'h48, 8'h20, 8'h7e});
		configure(5'd0, 1'b1, 1'b1);
		send_bytes('{8'h4b, 8'h0c, 8'h79});
		send_bytes('{8'h51});
	endtask

	task automatic test_store_limit();
		configure(5'($urandom_range(31)), 1'($urandom_range(1)), 1'b1);
		// the overflow flag must clear for the full but not overflowing message
		send_message(MaxLen + 2);
		send_message(MaxLen);
		configure(5'($urandom_range(31)), 1'($urandom_range(1)), 1'b1);
		send_message(MaxLen + 1);
	endtask

	task automatic test_random_messages();
		logic [4:0] k;
		while (words_sent < RandomStop) begin
			case ($urandom_range(5))
				0: k = 5'd0;
				1: k = 5'd26;
				2: k = 5'd31;
				default: k = 5'($urandom_range(31));
			endcase
			configure(k, 1'($urandom_range(1)), 1'($urandom_range(1)));
			in_gap_pct = 20 * $urandom_range(2);
			out_stall_pct = 20 * $urandom_range(2);
			repeat ($urandom_range(3, 8))
				send_message(($urandom_range(4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
		end
	endtask

	task automatic test_full_rate();
		calm = 1'b1;
		configure(5'($urandom_range(31)), 1'($urandom_range(1)), 1'b0);
		repeat (3) send_message($urandom_range(2, 8));
		configure(5'($urandom_range(31)), 1'($urandom_range(1)), 1'b1);
		repeat (3) send_message($urandom_range(2, 8));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_forward();
		test_key_wrap();
		test_reverse_short();
		test_store_limit();
		test_random_messages();
		test_full_rate();
		wait_idle();
		if (err_count == 0 && expected_words.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
